### sv/ssd_pkg.sv
`default_nettype none
package ssd_pkg;

  localparam int DEF_MAX_DEPTH = 3;
  localparam int DEF_FRAC_BITS = 14;
  localparam int EXTRA_BITS    = 14;
  localparam int COORD_W       = 16;
  localparam int LVL_W         = 2;
  localparam int CHILD_W       = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [1:0] depth_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vert_t;

  typedef struct packed {
    vert_t a;
    vert_t b;
    vert_t c;
  } face_t;

  typedef struct packed {
    vert_t m0;
    vert_t m1;
    vert_t m2;
  } mids_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } corners_t;

  typedef struct packed {
    coord_t out_a_x;
    coord_t out_a_y;
    coord_t out_a_z;
    coord_t out_b_x;
    coord_t out_b_y;
    coord_t out_b_z;
    coord_t out_c_x;
    coord_t out_c_y;
    coord_t out_c_z;
    logic   last_leaf;
  } leaf_t;

  typedef logic [1:0] mid_sel_t;
  localparam mid_sel_t MID_AB = 2'd0;
  localparam mid_sel_t MID_AC = 2'd1;
  localparam mid_sel_t MID_CB = 2'd2;

  localparam logic [CHILD_W-1:0] CHILD_FIRST = 2'd0;
  localparam logic [CHILD_W-1:0] CHILD_LAST  = 2'd3;

  typedef struct packed {
    logic               load;
    logic               proj_start;
    logic               proj_store;
    mid_sel_t           mid_sel;
    logic               child_wr;
    logic [CHILD_W-1:0] child_sel;
    logic               emit;
    logic               last;
    logic [LVL_W-1:0]   lvl;
  } dp_cmd_t;

  typedef struct packed {
    logic proj_busy;
    logic proj_done;
    logic out_full;
  } dp_status_t;

  // Representation of +1, saturated to the coordinate field.
  function automatic coord_t coord_lim(int frac_bits);
    int one;
    one = 1 << frac_bits;
    return (one < 32767) ? COORD_W'(one) : COORD_W'(32767);
  endfunction

  function automatic coord_t clamp_coord(coord_t v, coord_t lim);
    coord_t r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/ssd_ifs.sv
`default_nettype none
interface ssd_face_if;
  import ssd_pkg::*;
  logic     valid;
  logic     ready;
  corners_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssd_leaf_if;
  import ssd_pkg::*;
  logic  valid;
  logic  ready;
  leaf_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssd_depth_if;
  import ssd_pkg::*;
  logic   valid;
  logic   ready;
  depth_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/sphere_triangle_subdivider_core.sv
`default_nettype none
// Icosphere triangle subdivider.
// corners (valid/ready) carries one triangle on the unit sphere, signed Q1.14
// per coordinate by default. leaves (valid/ready) returns the leaf triangles
// of the midpoint subdivision, depth first, 4^depth per input, the final one
// with last_leaf set. cfg writes the subdivision depth (reset value 3, capped
// at MAX_DEPTH); write it only while no triangle is in flight.
// A new triangle is accepted only after the previous one has issued its last
// leaf into the output register. Each internal triangle needs three projected
// midpoints from one shared projection unit: a start step, squaring of the
// three coordinate sums, a zero check, 31 square-root steps, a load and
// divide per coordinate, and a done step. Depth 3 has 21 internal triangles,
// projected one midpoint at a time; depth 0 issues the input as its leaf.
// The output register holds a leaf while leaves.ready is low, and the walk
// waits there; nothing is dropped. Synchronous reset returns the controller
// to idle, empties the output register and sets the depth back to 3.
module sphere_triangle_subdivider_core #(
  parameter int MAX_DEPTH = ssd_pkg::DEF_MAX_DEPTH,
  parameter int FRAC_BITS = ssd_pkg::DEF_FRAC_BITS
) (
  input  logic  clk,
  input  logic  rst,
  ssd_face_if.sink    corners,
  ssd_leaf_if.source  leaves,
  ssd_depth_if.sink   cfg
);
  import ssd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ssd_ctrl #(.MAX_DEPTH(MAX_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (corners.valid),
    .in_ready  (corners.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_data  (cfg.data),
    .status    (status),
    .cmd       (cmd)
  );

  ssd_dp #(.MAX_DEPTH(MAX_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (corners.data),
    .out_valid (leaves.valid),
    .out_ready (leaves.ready),
    .out_data  (leaves.data)
  );

endmodule
`default_nettype wire

### sv/ssd_proj.sv
`default_nettype none
module ssd_proj #(
  parameter int FRAC_BITS = ssd_pkg::DEF_FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ssd_pkg::vert_t p,
  input  ssd_pkg::vert_t q,
  output logic          busy,
  output logic          done,
  output ssd_pkg::vert_t m
);
  import ssd_pkg::*;

  localparam int MAG_W  = COORD_W;
  localparam int SQ_W   = 2 * MAG_W + 2;
  localparam int N_W    = SQ_W + 2 * EXTRA_BITS;
  localparam int R_W    = N_W / 2;
  localparam int QB     = 17;
  localparam int NUM_W  = MAG_W + FRAC_BITS + EXTRA_BITS + 1;
  localparam int CMP_W  = (NUM_W > R_W + QB) ? NUM_W : R_W + QB;
  localparam int RC_W   = $clog2(R_W);
  localparam int DI_W   = $clog2(QB + 1);
  localparam coord_t LIM = coord_lim(FRAC_BITS);

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_SQ    = 3'd1;
  localparam logic [2:0] P_CHK   = 3'd2;
  localparam logic [2:0] P_ROOT  = 3'd3;
  localparam logic [2:0] P_DLOAD = 3'd4;
  localparam logic [2:0] P_DIV   = 3'd5;
  localparam logic [2:0] P_DONE  = 3'd6;

  logic [2:0]        st;
  logic [MAG_W-1:0]  mag [3];
  logic              neg [3];
  logic [1:0]        k;
  logic [SQ_W-1:0]   l2;
  logic [N_W-1:0]    n;
  logic [N_W-1:0]    res;
  logic [N_W-1:0]    bitv;
  logic [RC_W-1:0]   rcnt;
  logic [CMP_W-1:0]  rem;
  logic [QB-1:0]     quo;
  logic              sat;
  logic [DI_W-1:0]   di;
  coord_t            mres [3];

  logic signed [COORD_W:0] s [3];
  logic [MAG_W-1:0]        mag_k;
  logic [2*MAG_W-1:0]      sq;
  logic [N_W-1:0]          trial;
  logic [CMP_W-1:0]        dshift;
  logic                    ge;
  logic [QB-1:0]           qfin;
  logic [MAG_W-1:0]        qmag;

  always_comb begin
    s[0] = {p.x[COORD_W-1], p.x} + {q.x[COORD_W-1], q.x};
    s[1] = {p.y[COORD_W-1], p.y} + {q.y[COORD_W-1], q.y};
    s[2] = {p.z[COORD_W-1], p.z} + {q.z[COORD_W-1], q.z};
    mag_k  = mag[k];
    sq     = mag_k * mag_k;
    trial  = res + bitv;
    dshift = CMP_W'(res[R_W-1:0]) << di;
    ge     = rem >= dshift;
    qfin   = {quo[QB-2:0], ge};
    if (sat || (qfin > QB'(LIM))) begin
      qmag = MAG_W'(LIM);
    end else begin
      qmag = qfin[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= P_IDLE;
    end else begin
      case (st)
        P_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= s[i][COORD_W];
              mag[i] <= s[i][COORD_W] ? MAG_W'(-s[i]) : MAG_W'(s[i]);
            end
            k  <= 2'd0;
            l2 <= '0;
            st <= P_SQ;
          end
        end
        P_SQ: begin
          l2 <= l2 + SQ_W'(sq);
          if (k == 2'd2) begin
            st <= P_CHK;
          end else begin
            k <= k + 2'd1;
          end
        end
        P_CHK: begin
          if (l2 == '0) begin
            // A zero-length midpoint projects to the origin.
            for (int i = 0; i < 3; i++) begin
              mres[i] <= '0;
            end
            st <= P_DONE;
          end else begin
            n    <= N_W'(l2) << (2 * EXTRA_BITS);
            res  <= '0;
            bitv <= N_W'(1) << (N_W - 2);
            rcnt <= RC_W'(R_W - 1);
            st   <= P_ROOT;
          end
        end
        P_ROOT: begin
          if (n >= trial) begin
            n   <= n - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          rcnt <= rcnt - RC_W'(1);
          if (rcnt == '0) begin
            k  <= 2'd0;
            st <= P_DLOAD;
          end
        end
        P_DLOAD: begin
          // Rounded half up: the numerator carries half the divisor.
          rem <= (CMP_W'(mag_k) << (FRAC_BITS + EXTRA_BITS)) + CMP_W'(res[R_W-1:1]);
          quo <= '0;
          sat <= 1'b0;
          di  <= DI_W'(QB);
          st  <= P_DIV;
        end
        P_DIV: begin
          if (di == DI_W'(QB)) begin
            sat <= ge;
          end else begin
            if (ge) begin
              rem <= rem - dshift;
            end
            quo <= qfin;
          end
          if (di == '0) begin
            mres[k] <= neg[k] ? -coord_t'(qmag) : coord_t'(qmag);
            if (k == 2'd2) begin
              st <= P_DONE;
            end else begin
              k  <= k + 2'd1;
              st <= P_DLOAD;
            end
          end else begin
            di <= di - DI_W'(1);
          end
        end
        P_DONE: begin
          st <= P_IDLE;
        end
        default: begin
          st <= P_IDLE;
        end
      endcase
    end
  end

  assign busy = (st != P_IDLE);
  assign done = (st == P_DONE);
  assign m    = '{x: mres[0], y: mres[1], z: mres[2]};

endmodule
`default_nettype wire

### sv/ssd_dp.sv
`default_nettype none
module ssd_dp #(
  parameter int MAX_DEPTH = ssd_pkg::DEF_MAX_DEPTH,
  parameter int FRAC_BITS = ssd_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  ssd_pkg::dp_cmd_t    cmd,
  output ssd_pkg::dp_status_t status,
  input  ssd_pkg::corners_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssd_pkg::leaf_t      out_data
);
  import ssd_pkg::*;

  localparam int SW = $clog2(MAX_DEPTH + 1);
  localparam coord_t LIM = coord_lim(FRAC_BITS);

  face_t stack [MAX_DEPTH+1];
  mids_t mids  [MAX_DEPTH+1];

  logic [SW-1:0] ix;
  logic [SW-1:0] wix;
  face_t         rd;
  mids_t         mrd;
  vert_t         pp;
  vert_t         pq;
  vert_t         pm;
  logic          pbusy;
  logic          pdone;
  face_t         child;
  face_t         in_face;

  assign ix  = cmd.lvl[SW-1:0];
  assign wix = ix + SW'(1);
  assign rd  = stack[ix];
  assign mrd = mids[ix];

  always_comb begin
    in_face.a.x = clamp_coord(in_data.a_x, LIM);
    in_face.a.y = clamp_coord(in_data.a_y, LIM);
    in_face.a.z = clamp_coord(in_data.a_z, LIM);
    in_face.b.x = clamp_coord(in_data.b_x, LIM);
    in_face.b.y = clamp_coord(in_data.b_y, LIM);
    in_face.b.z = clamp_coord(in_data.b_z, LIM);
    in_face.c.x = clamp_coord(in_data.c_x, LIM);
    in_face.c.y = clamp_coord(in_data.c_y, LIM);
    in_face.c.z = clamp_coord(in_data.c_z, LIM);
  end

  always_comb begin
    case (cmd.mid_sel)
      MID_AB: begin
        pp = rd.a;
        pq = rd.b;
      end
      MID_AC: begin
        pp = rd.a;
        pq = rd.c;
      end
      MID_CB: begin
        pp = rd.c;
        pq = rd.b;
      end
      default: begin
        pp = rd.a;
        pq = rd.b;
      end
    endcase
  end

  always_comb begin
    case (cmd.child_sel)
      2'd0:    child = '{a: rd.a,   b: mrd.m0, c: mrd.m1};
      2'd1:    child = '{a: mrd.m0, b: rd.b,   c: mrd.m2};
      2'd2:    child = '{a: mrd.m0, b: mrd.m1, c: mrd.m2};
      default: child = '{a: mrd.m1, b: mrd.m2, c: rd.c};
    endcase
  end

  ssd_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.proj_start),
    .p     (pp),
    .q     (pq),
    .busy  (pbusy),
    .done  (pdone),
    .m     (pm)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stack[0] <= in_face;
    end
    if (cmd.child_wr) begin
      stack[wix] <= child;
    end
    if (cmd.proj_store) begin
      case (cmd.mid_sel)
        MID_AB:  mids[ix].m0 <= pm;
        MID_AC:  mids[ix].m1 <= pm;
        default: mids[ix].m2 <= pm;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= '{out_a_x: rd.a.x, out_a_y: rd.a.y, out_a_z: rd.a.z,
                    out_b_x: rd.b.x, out_b_y: rd.b.y, out_b_z: rd.b.z,
                    out_c_x: rd.c.x, out_c_y: rd.c.y, out_c_z: rd.c.z,
                    last_leaf: cmd.last};
    end
  end

  assign status.proj_busy = pbusy;
  assign status.proj_done = pdone;
  assign status.out_full  = out_valid && !out_ready;

endmodule
`default_nettype wire

### sv/ssd_ctrl.sv
`default_nettype none
module ssd_ctrl #(
  parameter int MAX_DEPTH = ssd_pkg::DEF_MAX_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ssd_pkg::depth_t     cfg_data,
  input  ssd_pkg::dp_status_t status,
  output ssd_pkg::dp_cmd_t    cmd
);
  import ssd_pkg::*;

  localparam int CW = $clog2(MAX_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VISIT = 3'd1;
  localparam logic [2:0] S_PGO   = 3'd2;
  localparam logic [2:0] S_PWAIT = 3'd3;
  localparam logic [2:0] S_DOWN  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_ADV   = 3'd6;

  logic [2:0]         st;
  logic [2:0]         st_next;
  logic [LVL_W-1:0]   lvl;
  logic [LVL_W-1:0]   lvl_next;
  logic [LVL_W-1:0]   dep;
  logic [LVL_W-1:0]   dep_next;
  depth_t             depth;
  mid_sel_t           msel;
  mid_sel_t           msel_next;
  logic [CHILD_W-1:0] child      [MAX_DEPTH+1];
  logic [CHILD_W-1:0] child_next [MAX_DEPTH+1];

  logic [LVL_W-1:0] parent;
  logic             last;

  assign parent    = lvl - LVL_W'(1);
  assign in_ready  = (st == S_IDLE) && !rst;
  assign cfg_ready = !rst;

  // The leaf is the final one when every level above it sits on its last child.
  always_comb begin
    last = 1'b1;
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if ((LVL_W'(j) < dep) && (child[j] != CHILD_LAST)) begin
        last = 1'b0;
      end
    end
  end

  always_comb begin
    st_next    = st;
    lvl_next   = lvl;
    dep_next   = dep;
    msel_next  = msel;
    child_next = child;
    cmd        = '0;
    cmd.lvl    = lvl;
    cmd.mid_sel = msel;
    cmd.last   = last;
    case (st)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          lvl_next = '0;
          dep_next = (depth > LVL_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH) : depth;
          st_next  = S_VISIT;
        end
      end
      S_VISIT: begin
        if (lvl == dep) begin
          st_next = S_EMIT;
        end else begin
          msel_next = MID_AB;
          st_next   = S_PGO;
        end
      end
      S_PGO: begin
        if (!status.proj_busy) begin
          cmd.proj_start = 1'b1;
          st_next        = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (status.proj_done) begin
          cmd.proj_store = 1'b1;
          case (msel)
            MID_AB: begin
              msel_next = MID_AC;
              st_next   = S_PGO;
            end
            MID_AC: begin
              msel_next = MID_CB;
              st_next   = S_PGO;
            end
            default: begin
              st_next = S_DOWN;
            end
          endcase
        end
      end
      S_DOWN: begin
        cmd.child_wr          = 1'b1;
        cmd.child_sel         = CHILD_FIRST;
        child_next[lvl[CW-1:0]] = CHILD_FIRST;
        lvl_next              = lvl + LVL_W'(1);
        st_next               = S_VISIT;
      end
      S_EMIT: begin
        if (!status.out_full) begin
          cmd.emit = 1'b1;
          st_next  = S_ADV;
        end
      end
      S_ADV: begin
        cmd.lvl = parent;
        if (lvl == '0) begin
          st_next = S_IDLE;
        end else if (child[parent[CW-1:0]] == CHILD_LAST) begin
          lvl_next = parent;
        end else begin
          cmd.child_wr               = 1'b1;
          cmd.child_sel              = child[parent[CW-1:0]] + CHILD_W'(1);
          child_next[parent[CW-1:0]] = child[parent[CW-1:0]] + CHILD_W'(1);
          st_next                    = S_VISIT;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      lvl   <= '0;
      dep   <= '0;
      msel  <= MID_AB;
      depth <= 2'd3;
      for (int j = 0; j <= MAX_DEPTH; j++) begin
        child[j] <= CHILD_FIRST;
      end
    end else begin
      st    <= st_next;
      lvl   <= lvl_next;
      dep   <= dep_next;
      msel  <= msel_next;
      child <= child_next;
      if (cfg_valid) begin
        depth <= cfg_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_lvl_in_range: assert property (@(posedge clk) disable iff (rst)
    (st != S_IDLE) |-> (lvl <= dep))
    else $error("level pointer beyond the active depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_full)
    else $error("leaf issued while the output register is held");

  a_proj_free: assert property (@(posedge clk) disable iff (rst)
    cmd.proj_start |-> !status.proj_busy)
    else $error("projection started while the unit is busy");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    status.proj_done |-> (st == S_PWAIT))
    else $error("projection finished with no request pending");
`endif

endmodule
`default_nettype wire
